// ----- rtl/mexp_pkg.sv -----
package mexp_pkg;

  // configuration register indexes
  localparam int CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MODULUS  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_EXPONENT = 1'b1;

  // register reset values
  localparam int MODULUS_DEFAULT  = 1;
  localparam int EXPONENT_DEFAULT = 65537;

  // top level sequencer
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_REDUCE = 6'b000010,
    S_CHECK  = 6'b000100,
    S_MUL    = 6'b001000,
    S_SQR    = 6'b010000,
    S_WRITE  = 6'b100000
  } mexp_state_t;

  // modular multiplier sequencer
  typedef enum logic [2:0] {
    M_IDLE = 3'b001,
    M_DBL  = 3'b010,
    M_ADD  = 3'b100
  } mexp_mul_state_t;

  // multiplier status back to the top level
  typedef struct packed {
    logic busy;
    logic done;
  } mexp_mul_stat_t;

endpackage

// ----- rtl/mexp_if.sv -----
// message channel
interface mexp_msg_if #(
  parameter int WORD_BITS = 62
);
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] message;

  modport source (output valid, output message, input ready);
  modport sink (input valid, input message, output ready);
endinterface

// result channel
interface mexp_pow_if #(
  parameter int WORD_BITS = 62
);
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] power_value;

  modport source (output valid, output power_value, input ready);
  modport sink (input valid, input power_value, output ready);
endinterface

// configuration write channel
interface mexp_cfg_if #(
  parameter int WORD_BITS = 62
);
  import mexp_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [WORD_BITS-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/mexp_modadd.sv -----
module mexp_modadd #(
  parameter int WORD_BITS = 62
) (
  input  logic [WORD_BITS-1:0] x,
  input  logic [WORD_BITS-1:0] y,
  input  logic [WORD_BITS-1:0] modulus,
  output logic [WORD_BITS-1:0] sum
);
  logic [WORD_BITS:0]   raw;
  logic [WORD_BITS+1:0] diff;
  logic                 ge;

  // add, then one conditional subtract of the modulus
  // a zero modulus wraps at the word width
  assign raw  = {1'b0, x} + {1'b0, y};
  assign diff = {1'b0, raw} - {2'b00, modulus};
  assign ge   = !diff[WORD_BITS+1] && (modulus != '0);
  assign sum  = ge ? diff[WORD_BITS-1:0] : raw[WORD_BITS-1:0];

endmodule

// ----- rtl/mexp_modmul.sv -----
module mexp_modmul #(
  parameter int WORD_BITS = 62
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [WORD_BITS-1:0]     a_in,
  input  logic [WORD_BITS-1:0]     b_in,
  input  logic [WORD_BITS-1:0]     modulus,
  output logic [WORD_BITS-1:0]     product,
  output mexp_pkg::mexp_mul_stat_t stat
);
  import mexp_pkg::*;

  localparam int CNT_BITS = $clog2(WORD_BITS);

  mexp_mul_state_t      state, state_next;
  logic [WORD_BITS-1:0] p;
  logic [WORD_BITS-1:0] a;
  logic [WORD_BITS-1:0] b;
  logic [CNT_BITS-1:0]  cnt;
  logic                 done;
  logic                 done_next;
  logic [WORD_BITS-1:0] add_y;
  logic [WORD_BITS-1:0] sum;
  logic                 last_bit;

  // shared add and reduce: doubles p, or adds the multiplicand
  assign add_y = (state == M_ADD) ? a : p;

  mexp_modadd #(.WORD_BITS(WORD_BITS)) u_add (
    .x       (p),
    .y       (add_y),
    .modulus (modulus),
    .sum     (sum)
  );

  assign last_bit = (cnt == '0);

  // msb-first double and add over the multiplier bits
  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    case (state)
      M_IDLE: begin
        if (start) state_next = M_DBL;
      end
      M_DBL: begin
        if (b[WORD_BITS-1]) begin
          state_next = M_ADD;
        end else if (last_bit) begin
          state_next = M_IDLE;
          done_next  = 1'b1;
        end
      end
      M_ADD: begin
        if (last_bit) begin
          state_next = M_IDLE;
          done_next  = 1'b1;
        end else begin
          state_next = M_DBL;
        end
      end
      default: state_next = M_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      M_IDLE: begin
        if (start) begin
          p   <= '0;
          a   <= a_in;
          b   <= b_in;
          cnt <= CNT_BITS'(WORD_BITS - 1);
        end
      end
      M_DBL: begin
        p <= sum;
        if (!b[WORD_BITS-1] && !last_bit) begin
          b   <= {b[WORD_BITS-2:0], 1'b0};
          cnt <= cnt - 1'b1;
        end
      end
      M_ADD: begin
        p <= sum;
        if (!last_bit) begin
          b   <= {b[WORD_BITS-2:0], 1'b0};
          cnt <= cnt - 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign product   = p;
  assign stat.busy = (state != M_IDLE);
  assign stat.done = done;

  // a new product is only launched on a free unit
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> (state == M_IDLE))
    else $error("multiplier started while busy");

  // an add step always follows a double step
  a_add_after_dbl: assert property (@(posedge clk) disable iff (rst)
    (state == M_ADD) |-> ($past(state) == M_DBL))
    else $error("add step without preceding double");

  // the finished product is reported with the unit back at rest
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == M_IDLE))
    else $error("done while still working");

endmodule

// ----- rtl/modular_exponentiation.sv -----
// channel   dir  payload            handshake
// msg       in   message            valid/ready
// result    out  power_value        valid/ready
// cfg       in   index, data        valid/ready (ready always high)
//
// one word takes one reduction of the message and then P modular products, where P is
// popcount(exponent) + bit length of exponent - 1; each product is a double and add over
// the multiplier bits in the one shared add-and-reduce unit doing one double or add per cycle.
// a zero exponent skips the multiplier and goes straight to the write state.
// reset is synchronous, clears control state and loads the register defaults only; no clearing pass.
// the result register holds a word until taken; the next message is taken meanwhile.
module modular_exponentiation #(
  parameter int WORD_BITS = 62
) (
  input  logic              clk,
  input  logic              rst,
  mexp_msg_if.sink          msg,
  mexp_pow_if.source        result,
  mexp_cfg_if.sink          cfg
);
  import mexp_pkg::*;

  mexp_state_t          state, state_next;
  logic [WORD_BITS-1:0] modulus;
  logic [WORD_BITS-1:0] exponent;
  logic [WORD_BITS-1:0] acc;
  logic [WORD_BITS-1:0] base;
  logic [WORD_BITS-1:0] exp_left;
  logic [WORD_BITS-1:0] res_data;
  logic                 res_valid;
  logic [WORD_BITS-1:0] one_red;
  logic                 in_acc;
  logic                 res_load;
  logic                 mul_start;
  logic [WORD_BITS-1:0] mul_a;
  logic [WORD_BITS-1:0] mul_b;
  logic [WORD_BITS-1:0] mul_product;
  mexp_mul_stat_t       mul_stat;

  // configuration writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus  <= WORD_BITS'(MODULUS_DEFAULT);
      exponent <= WORD_BITS'(EXPONENT_DEFAULT);
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_MODULUS:  modulus  <= cfg.data;
        REG_EXPONENT: exponent <= cfg.data;
        default: ;
      endcase
    end
  end

  // one reduced modulo the modulus
  assign one_red = (modulus == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);

  assign msg.ready = (state == S_IDLE);
  assign in_acc    = msg.valid && msg.ready;
  assign res_load  = (state == S_WRITE) && (!res_valid || result.ready);

  // product launch: reduce the message, then multiply or square per exponent bit
  always_comb begin
    mul_start = 1'b0;
    mul_a     = base;
    mul_b     = base;
    case (state)
      S_IDLE: begin
        mul_start = in_acc && (exponent != '0);
        mul_a     = one_red;
        mul_b     = msg.message;
      end
      S_CHECK: begin
        mul_start = (exp_left != '0);
        if (exp_left[0]) mul_a = acc;
      end
      default: ;
    endcase
  end

  mexp_modmul #(.WORD_BITS(WORD_BITS)) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a_in    (mul_a),
    .b_in    (mul_b),
    .modulus (modulus),
    .product (mul_product),
    .stat    (mul_stat)
  );

  // exponent sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc) state_next = (exponent == '0) ? S_WRITE : S_REDUCE;
      end
      S_REDUCE: begin
        if (mul_stat.done) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (exp_left == '0) state_next = S_WRITE;
        else if (exp_left[0]) state_next = S_MUL;
        else state_next = S_SQR;
      end
      S_MUL: begin
        if (mul_stat.done) state_next = S_CHECK;
      end
      S_SQR: begin
        if (mul_stat.done) state_next = S_CHECK;
      end
      S_WRITE: begin
        if (res_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res_load) res_valid <= 1'b1;
      else if (result.ready) res_valid <= 1'b0;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          exp_left <= exponent;
          acc      <= (exponent == '0) ? WORD_BITS'(1) : one_red;
        end
      end
      S_REDUCE: begin
        if (mul_stat.done) base <= mul_product;
      end
      S_MUL: begin
        if (mul_stat.done) begin
          acc         <= mul_product;
          exp_left[0] <= 1'b0;
        end
      end
      S_SQR: begin
        if (mul_stat.done) begin
          base     <= mul_product;
          exp_left <= {1'b0, exp_left[WORD_BITS-1:1]};
        end
      end
      default: ;
    endcase
    if (res_load) res_data <= acc;
  end

  assign result.valid       = res_valid;
  assign result.power_value = res_data;

  // the shared unit is at rest whenever a message can be taken
  a_idle_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mul_stat.busy)
    else $error("multiplier busy while idle");

  // a finished product only arrives in a waiting state
  a_done_state: assert property (@(posedge clk) disable iff (rst)
    mul_stat.done |-> (state == S_REDUCE || state == S_MUL || state == S_SQR))
    else $error("product finished in wrong state");

  // exhausted exponent goes straight to the result
  a_exp_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK && exp_left == '0) |=> (state == S_WRITE))
    else $error("exponent done but no result");

  // the result register takes the accumulator
  a_res_load: assert property (@(posedge clk) disable iff (rst)
    res_load |=> (res_valid && res_data == $past(acc)))
    else $error("result word not loaded");

endmodule

// ----- bench/mexp_power_check.sv -----
`timescale 1ns / 100ps
module mexp_power_check #(
  parameter int WORD_BITS = 62
) (
  input  logic clk,
  input  logic rst,
  mexp_msg_if  msg,
  mexp_pow_if  result,
  mexp_cfg_if  cfg,
  output int   errors,
  output int   awaiting
);
  import mexp_pkg::*;

  typedef logic [WORD_BITS-1:0]   word_t;
  typedef logic [2*WORD_BITS-1:0] wide_t;

  word_t modulus_q;
  word_t exponent_q;
  word_t power_due[$];

  // one modular product; a zero modulus wraps to the word
  function automatic word_t mul_mod(word_t a, word_t b);
    wide_t full;
    wide_t rem;
    full = wide_t'(a) * wide_t'(b);
    if (modulus_q == '0) return full[WORD_BITS-1:0];
    rem = full % wide_t'(modulus_q);
    return rem[WORD_BITS-1:0];
  endfunction

  // square and multiply over the exponent bits, low bit first
  // a zero exponent leaves the accumulator at one, unreduced
  function automatic word_t predict_power(word_t base);
    word_t acc;
    word_t sq;
    acc = word_t'(1);
    sq  = base;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (exponent_q[i]) acc = mul_mod(acc, sq);
      sq = mul_mod(sq, sq);
    end
    return acc;
  endfunction

  always @(posedge clk) begin
    word_t want;
    if (rst) begin
      modulus_q  = word_t'(MODULUS_DEFAULT);
      exponent_q = word_t'(EXPONENT_DEFAULT);
      power_due.delete();
    end else begin
      // shadow register writes
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_MODULUS) modulus_q = cfg.data;
        else if (cfg.index == REG_EXPONENT) exponent_q = cfg.data;
      end
      // delivered word against the oldest prediction
      if (result.valid && result.ready) begin
        if (power_due.size() == 0) begin
          errors++;
          $display("%0t: power_value %h delivered with none expected", $time,
                   result.power_value);
        end else begin
          want = power_due.pop_front();
          if (result.power_value !== want) begin
            errors++;
            $display("%0t: power_value mismatch: expected %h, actual %h", $time, want,
                     result.power_value);
          end
        end
      end
      // predict each accepted message word
      if (msg.valid && msg.ready) power_due.push_back(predict_power(msg.message));
    end
    awaiting = power_due.size();
  end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
module tb_top;
  import mexp_pkg::*;

  localparam int WORD_BITS     = 62;
  localparam int STALL_LIMIT   = 100000;
  localparam int SETTLE_CYCLES = 50;

  typedef logic [WORD_BITS-1:0] word_t;
  localparam word_t WORD_MAX = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   send_idle_pct = 36;
  int   recv_idle_pct = 76;
  int   errors;
  int   awaiting;
  int   stall_cycles;

  mexp_msg_if #(.WORD_BITS(WORD_BITS)) msg_ch ();
  mexp_pow_if #(.WORD_BITS(WORD_BITS)) pow_ch ();
  mexp_cfg_if #(.WORD_BITS(WORD_BITS)) cfg_ch ();

  modular_exponentiation #(.WORD_BITS(WORD_BITS)) dut (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg_ch),
    .result (pow_ch),
    .cfg    (cfg_ch)
  );

  mexp_power_check #(.WORD_BITS(WORD_BITS)) power_check (
    .clk      (clk),
    .rst      (rst),
    .msg      (msg_ch),
    .result   (pow_ch),
    .cfg      (cfg_ch),
    .errors   (errors),
    .awaiting (awaiting)
  );

  always #5 clk = ~clk;

  // random back-pressure on the result channel
  initial begin
    pow_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      pow_ch.ready = !rst && (int'($urandom_range(99)) >= recv_idle_pct);
    end
  end

  // watchdog on cycles with no word moving on any channel
  always @(posedge clk) begin
    if (rst || (msg_ch.valid && msg_ch.ready) || (pow_ch.valid && pow_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic word_t rand_word();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[WORD_BITS-1:0];
  endfunction

  // offer one message word, with random idle cycles ahead of it
  task automatic send_word(input word_t w);
    while (int'($urandom_range(99)) < send_idle_pct) @(negedge clk);
    msg_ch.valid   = 1'b1;
    msg_ch.message = w;
    @(posedge clk);
    while (!msg_ch.ready) @(posedge clk);
    @(negedge clk);
    msg_ch.valid = 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input word_t value);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic drain();
    while (awaiting != 0) @(negedge clk);
  endtask

  // new key only once every result is back
  task automatic configure(input word_t m, input word_t e);
    drain();
    write_reg(REG_MODULUS, m);
    write_reg(REG_EXPONENT, e);
  endtask

  // random key, then a batch of message words under it
  task automatic random_phase(input int count, input bit full_exponent);
    word_t m;
    word_t e;
    word_t w;
    word_t p;
    word_t q;
    int    len;
    case ($urandom_range(4))
      0: m = rand_word() | word_t'(1);
      1: m = word_t'($urandom_range(5000, 2));
      2: begin
        // rsa-like modulus from two odd 31-bit factors
        p = (rand_word() >> 31) | (word_t'(1) << 30) | word_t'(1);
        q = (rand_word() >> 31) | (word_t'(1) << 30) | word_t'(1);
        m = p * q;
      end
      3: m = word_t'(1) << $urandom_range(61, 1);
      default: m = WORD_MAX - word_t'($urandom_range(100));
    endcase
    if (full_exponent) begin
      e = rand_word() | (word_t'(1) << (WORD_BITS - 1));
    end else begin
      case ($urandom_range(3))
        0: e = word_t'(EXPONENT_DEFAULT);
        1: e = word_t'($urandom_range(3));
        default: begin
          // short exponents of 1 to 20 bits, top bit set, keep each word's run short
          len = $urandom_range(20, 1);
          e   = (rand_word() & ((word_t'(1) << len) - 1)) | (word_t'(1) << (len - 1));
        end
      endcase
    end
    configure(m, e);
    repeat (count) begin
      case ($urandom_range(9))
        0: w = '0;
        1: w = word_t'(1);
        2: w = m - word_t'(1);
        3: w = rand_word() % m;
        default: w = rand_word();
      endcase
      send_word(w);
    end
  endtask

  initial begin
    msg_ch.valid   = 1'b0;
    msg_ch.message = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = REG_MODULUS;
    cfg_ch.data    = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset key: modulus one with the default exponent gives zero
    send_word('0);
    send_word(WORD_MAX);
    // zero exponent gives one, even with modulus one
    configure(word_t'(1), '0);
    send_word('0);
    send_word(WORD_MAX);
    send_word(word_t'(5));
    // largest modulus, small exponents, messages below and at the modulus
    configure(WORD_MAX, '0);
    send_word(WORD_MAX);
    configure(WORD_MAX, word_t'(1));
    send_word('0);
    send_word(WORD_MAX);
    send_word(WORD_MAX - 1);
    configure(WORD_MAX, word_t'(2));
    send_word(WORD_MAX - 1);
    send_word(word_t'(1) << 61);
    // zero modulus wraps every product to the word
    configure('0, word_t'(3));
    send_word(WORD_MAX);
    send_word(word_t'(3));
    send_word((word_t'(1) << 61) | word_t'(1));
    // modulus one with a nonzero exponent
    configure(word_t'(1), word_t'(5));
    send_word(rand_word());
    // textbook key pair, n = 61 * 53: encrypt then decrypt
    configure(word_t'(3233), word_t'(17));
    send_word(word_t'(65));
    configure(word_t'(3233), word_t'(2753));
    send_word(word_t'(2790));
    // largest exponent, the longest square-and-multiply run
    configure(WORD_MAX, WORD_MAX);
    send_word(WORD_MAX - 1);
    send_word(word_t'(2));

    // random keys, idling swapped then switched off
    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 3) begin
        send_idle_pct = 76;
        recv_idle_pct = 36;
      end
      if (ph == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_phase((ph == 4) ? 5 : 10, ph == 4);
    end

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (errors == 0 && awaiting == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
